[src/cba_pkg.sv]
// cba_pkg: shared types, codes and constants of the clipped blit address generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package cba_pkg;

  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int PLACE_W    = 14;
  localparam int SRC_IDX_W  = 26;
  localparam int DST_IDX_W  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;
  localparam int DEF_MAX_DIM = 4096;
  localparam logic [DIM_W-1:0] CFG_RESET_VAL = 13'd256;

  // operation codes carried in in_tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_H = 3'd3;

  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
  } cfg_regs_t;

  // one pixel pair request from front to back
  typedef struct packed {
    logic [DIM_W-1:0] src_row;
    logic [DIM_W-1:0] src_col;
    logic [DIM_W-1:0] dst_row;
    logic [DIM_W-1:0] dst_col;
    logic             last;
    logic             empty;
  } pair_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

[src/cba_front.sv]
// cba_front: accepts input transactions, clips start rectangles, sequences the pixel walk
// depends on cba_pkg; feeds pair requests into cba_queue
`timescale 1ns / 1ps

module cba_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cba_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  cba_pkg::cfg_regs_t            regs,
  input  cba_pkg::queue_status_t        q_status,
  output logic                          push,
  output cba_pkg::pair_req_t            push_req
);
  import cba_pkg::*;

  logic [COORD_W-1:0] clip_src_x_r, clip_src_x_nxt;
  logic [COORD_W-1:0] clip_src_y_r, clip_src_y_nxt;
  logic [DIM_W-1:0]   clip_w_r, clip_w_nxt;
  logic [DIM_W-1:0]   clip_h_r, clip_h_nxt;
  logic [COORD_W-1:0] clip_dst_x_r, clip_dst_x_nxt;
  logic [COORD_W-1:0] clip_dst_y_r, clip_dst_y_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic               busy_r, busy_nxt;

  logic                accept;
  logic [COORD_W-1:0]  sx, sy;
  logic [DIM_W-1:0]    sw, sh;
  logic [PLACE_W-1:0]  px, py;
  logic signed [15:0]  dx_in, dy_in;
  logic signed [15:0]  sw_reg, sh_reg, dw_reg, dh_reg;
  logic signed [15:0]  sx_a, sw_a, dx_a, w_lim, sw_b;
  logic signed [15:0]  sy_a, sh_a, dy_a, h_lim, sh_b;
  logic                rej_x, rej_y, clip_ok;
  logic [DIM_W-1:0]    col_inc, row_inc;
  logic                last;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  assign sx = in_tdata[11:0];
  assign sy = in_tdata[23:12];
  assign sw = in_tdata[36:24];
  assign sh = in_tdata[49:37];
  assign px = in_tdata[63:50];
  assign py = in_tdata[77:64];

  assign dx_in  = $signed({{2{px[PLACE_W-1]}}, px});
  assign dy_in  = $signed({{2{py[PLACE_W-1]}}, py});
  assign sw_reg = $signed({3'b0, regs.src_w});
  assign sh_reg = $signed({3'b0, regs.src_h});
  assign dw_reg = $signed({3'b0, regs.dst_w});
  assign dh_reg = $signed({3'b0, regs.dst_h});

  // vertical clip
  always_comb begin
    sy_a  = $signed({4'b0, sy});
    sh_a  = $signed({3'b0, sh});
    dy_a  = dy_in;
    rej_y = 1'b0;
    if (dy_in < 16'sd0) begin
      sy_a  = sy_a - dy_in;
      sh_a  = sh_a + dy_in;
      rej_y = sy_a > (sh_reg - 16'sd1);
      dy_a  = '0;
    end
    if (dy_a > (dh_reg - 16'sd1)) begin
      rej_y = 1'b1;
    end
    h_lim = dh_reg - dy_a;
    sh_b  = (sh_a > h_lim) ? h_lim : sh_a;
  end

  // horizontal clip, independent of the vertical one
  always_comb begin
    sx_a  = $signed({4'b0, sx});
    sw_a  = $signed({3'b0, sw});
    dx_a  = dx_in;
    rej_x = 1'b0;
    if (dx_in < 16'sd0) begin
      sx_a  = sx_a - dx_in;
      sw_a  = sw_a + dx_in;
      rej_x = sx_a > (sw_reg - 16'sd1);
      dx_a  = '0;
    end
    if (dx_a > (dw_reg - 16'sd1)) begin
      rej_x = 1'b1;
    end
    w_lim = dw_reg - dx_a;
    sw_b  = (sw_a > w_lim) ? w_lim : sw_a;
  end

  assign clip_ok = !rej_x && !rej_y && (sw_b > 16'sd0) && (sh_b > 16'sd0);

  assign col_inc = {1'b0, col_r} + 13'd1;
  assign row_inc = {1'b0, row_r} + 13'd1;
  assign last    = (col_inc >= clip_w_r) && (row_inc >= clip_h_r);

  always_comb begin
    clip_src_x_nxt = clip_src_x_r;
    clip_src_y_nxt = clip_src_y_r;
    clip_w_nxt     = clip_w_r;
    clip_h_nxt     = clip_h_r;
    clip_dst_x_nxt = clip_dst_x_r;
    clip_dst_y_nxt = clip_dst_y_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    busy_nxt       = busy_r;
    push           = 1'b0;
    push_req       = '0;
    if (accept) begin
      if (in_tuser == OP_START) begin
        col_nxt = '0;
        row_nxt = '0;
        if (clip_ok) begin
          // values passed the edge tests, so they fit the narrow fields
          clip_src_x_nxt = sx_a[COORD_W-1:0];
          clip_src_y_nxt = sy_a[COORD_W-1:0];
          clip_w_nxt     = sw_b[DIM_W-1:0];
          clip_h_nxt     = sh_b[DIM_W-1:0];
          clip_dst_x_nxt = dx_a[COORD_W-1:0];
          clip_dst_y_nxt = dy_a[COORD_W-1:0];
          busy_nxt       = 1'b1;
        end else begin
          // zero rows and columns make both indexes zero in the back end
          busy_nxt       = 1'b0;
          push           = 1'b1;
          push_req.empty = 1'b1;
        end
      end else if (busy_r) begin
        push             = 1'b1;
        push_req.src_row = {1'b0, clip_src_y_r} + {1'b0, row_r};
        push_req.src_col = {1'b0, clip_src_x_r} + {1'b0, col_r};
        push_req.dst_row = {1'b0, clip_dst_y_r} + {1'b0, row_r};
        push_req.dst_col = {1'b0, clip_dst_x_r} + {1'b0, col_r};
        push_req.last    = last;
        if (col_inc < clip_w_r) begin
          col_nxt = col_inc[COORD_W-1:0];
        end else begin
          col_nxt = '0;
          row_nxt = row_inc[COORD_W-1:0];
        end
        if (last) begin
          busy_nxt = 1'b0;
          col_nxt  = '0;
          row_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_src_x_r <= '0;
      clip_src_y_r <= '0;
      clip_w_r     <= '0;
      clip_h_r     <= '0;
      clip_dst_x_r <= '0;
      clip_dst_y_r <= '0;
      col_r        <= '0;
      row_r        <= '0;
      busy_r       <= 1'b0;
    end else begin
      clip_src_x_r <= clip_src_x_nxt;
      clip_src_y_r <= clip_src_y_nxt;
      clip_w_r     <= clip_w_nxt;
      clip_h_r     <= clip_h_nxt;
      clip_dst_x_r <= clip_dst_x_nxt;
      clip_dst_y_r <= clip_dst_y_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      busy_r       <= busy_nxt;
    end
  end

endmodule

[src/cba_queue.sv]
// cba_queue: short fifo of pair requests between front and back end
// depends on cba_pkg
`timescale 1ns / 1ps

module cba_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  cba_pkg::pair_req_t     wr_req,
  input  logic                   pop,
  output cba_pkg::pair_req_t     rd_req,
  output cba_pkg::queue_status_t status
);
  import cba_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pair_req_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_req       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[src/cba_back.sv]
// cba_back: two-stage multiply then add pipeline that turns pair requests into indexes
// depends on cba_pkg; drains cba_queue and drives the result stream
`timescale 1ns / 1ps

module cba_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cba_pkg::cfg_regs_t             regs,
  input  cba_pkg::queue_status_t         q_status,
  input  cba_pkg::pair_req_t             rd_req,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cba_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  output logic                           out_tuser
);
  import cba_pkg::*;

  localparam int PROD_W = 2 * DIM_W;

  // multiply stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [PROD_W-1:0] s1_src_prod_r, s1_dst_prod_r;
  logic [DIM_W-1:0]  s1_src_col_r, s1_dst_col_r;
  logic              s1_last_r, s1_empty_r;

  // output stage
  logic                 out_valid_r, out_valid_nxt;
  logic [SRC_IDX_W-1:0] out_src_r;
  logic [DST_IDX_W-1:0] out_dst_r;
  logic                 out_last_r, out_empty_r;

  logic out_free, s1_free;
  logic [PROD_W-1:0] src_sum, dst_sum;

  assign out_free = !out_valid_r || out_tready;
  assign s1_free  = !s1_valid_r || out_free;
  assign pop      = s1_free && !q_status.empty;

  assign src_sum = s1_src_prod_r + {{(PROD_W-DIM_W){1'b0}}, s1_src_col_r};
  assign dst_sum = s1_dst_prod_r + {{(PROD_W-DIM_W){1'b0}}, s1_dst_col_r};

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_free) begin
      s1_valid_nxt = pop;
    end
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_src_prod_r <= PROD_W'(rd_req.src_row) * PROD_W'(regs.src_w);
      s1_dst_prod_r <= PROD_W'(rd_req.dst_row) * PROD_W'(regs.dst_w);
      s1_src_col_r  <= rd_req.src_col;
      s1_dst_col_r  <= rd_req.dst_col;
      s1_last_r     <= rd_req.last;
      s1_empty_r    <= rd_req.empty;
    end
    if (out_free && s1_valid_r) begin
      out_src_r   <= src_sum[SRC_IDX_W-1:0];
      out_dst_r   <= dst_sum[DST_IDX_W-1:0];
      out_last_r  <= s1_last_r;
      out_empty_r <= s1_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-SRC_IDX_W-DST_IDX_W){1'b0}}, out_dst_r, out_src_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

endmodule

[src/clipped_blit_address_generator.sv]
// clipped_blit_address_generator: an accepted transaction passes the queue write, multiply
// stage and add stage before its result shows on out_tvalid; throughput is one transaction
// per cycle unless out_tready stalls, set by the front sequencer and the pipelined back end.
// reset (rst_n, synchronous, active low): idle, no blit running, queue and pipeline empty,
// all four dimension registers at 256
// depends on cba_pkg, cba_front, cba_queue, cba_back
`timescale 1ns / 1ps

module clipped_blit_address_generator #(
  parameter int MAX_DIM = cba_pkg::DEF_MAX_DIM
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // rect_src_x[11:0], rect_src_y[23:12], rect_width[36:24], rect_height[49:37],
  // place_x[63:50], place_y[77:64], zero pad
  input  logic [cba_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // src_index[25:0], dst_index[49:26], zero pad
  output logic [cba_pkg::OUT_DATA_W-1:0] out_tdata,
  // last_pair
  output logic                           out_tlast,
  // nothing_copied
  output logic                           out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cba_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [cba_pkg::DIM_W-1:0]      cfg_data
);
  import cba_pkg::*;

  cfg_regs_t        regs_r, regs_nxt;
  logic [DIM_W-1:0] cfg_sat;
  logic             cfg_write;

  queue_status_t q_status;
  pair_req_t     push_req, rd_req;
  logic          push, pop;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_sat   = ({19'b0, cfg_data} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_data;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_write) begin
      case (cfg_addr)
        CFG_SRC_W: regs_nxt.src_w = cfg_sat;
        CFG_SRC_H: regs_nxt.src_h = cfg_sat;
        CFG_DST_W: regs_nxt.dst_w = cfg_sat;
        CFG_DST_H: regs_nxt.dst_h = cfg_sat;
        default:   regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.src_w <= CFG_RESET_VAL;
      regs_r.src_h <= CFG_RESET_VAL;
      regs_r.dst_w <= CFG_RESET_VAL;
      regs_r.dst_h <= CFG_RESET_VAL;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  cba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .regs      (regs_r),
    .q_status  (q_status),
    .push      (push),
    .push_req  (push_req)
  );

  cba_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_req (push_req),
    .pop    (pop),
    .rd_req (rd_req),
    .status (q_status)
  );

  cba_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .regs       (regs_r),
    .q_status   (q_status),
    .rd_req     (rd_req),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // an empty-start result carries zero indexes and no last mark
  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == '0) && !out_tlast)
    else $error("empty result with nonzero payload");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_status.full))
    else $error("queue overflow");

  // oversized source width writes saturate
  a_cfg_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write && (cfg_addr == CFG_SRC_W) && ({19'b0, cfg_data} > 32'(MAX_DIM))
    |=> ({19'b0, regs_r.src_w} == 32'(MAX_DIM)))
    else $error("source width not saturated");

endmodule

[tb/cba_blit_checker.sv]
// cba_blit_checker: watches the config, input and result channels of the blit address generator,
// predicts every pixel pair and compares it with what leaves the block
// depends on cba_pkg
`timescale 1ns / 1ps

module cba_blit_checker #(
  parameter int MAX_DIM = cba_pkg::DEF_MAX_DIM
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [cba_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [cba_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tlast,
  input  logic                           out_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [cba_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [cba_pkg::DIM_W-1:0]      cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import cba_pkg::*;

  typedef struct packed {
    logic [SRC_IDX_W-1:0] src_index;
    logic [DST_IDX_W-1:0] dst_index;
    logic                 last_pair;
    logic                 nothing_copied;
  } pixel_pair_t;

  pixel_pair_t expected_pairs[$];

  // mirrored dimension registers
  int src_w, src_h, dst_w, dst_h;

  // clipped rectangle of the running blit
  int clip_sx, clip_sy, clip_w, clip_h, clip_dx, clip_dy;
  int col, row;
  bit busy;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // clips a start against the destination or emits the next pair of a running blit
  function automatic void predict_pixel_pair(input logic op, input logic [IN_DATA_W-1:0] d);
    int sx, sy, sw, sh, dx, dy;
    bit ok;
    longint si, di;
    pixel_pair_t p;
    if (op == OP_START) begin
      sx = int'(d[11:0]);
      sy = int'(d[23:12]);
      sw = int'(d[36:24]);
      sh = int'(d[49:37]);
      dx = int'($signed(d[63:50]));
      dy = int'($signed(d[77:64]));
      col = 0;
      row = 0;
      ok = 1'b1;
      // negative placement moves the source start and shrinks the size
      if (dy < 0) begin
        sy -= dy;
        sh += dy;
        if (sy > src_h - 1) ok = 1'b0;
        dy = 0;
      end
      if (ok && dy > dst_h - 1) ok = 1'b0;
      if (ok && sh > dst_h - dy) sh = dst_h - dy;
      if (ok && dx < 0) begin
        sx -= dx;
        sw += dx;
        if (sx > src_w - 1) ok = 1'b0;
        dx = 0;
      end
      if (ok && dx > dst_w - 1) ok = 1'b0;
      if (ok && sw > dst_w - dx) sw = dst_w - dx;
      if (sw <= 0 || sh <= 0) ok = 1'b0;
      if (ok) begin
        clip_sx = sx;
        clip_sy = sy;
        clip_w  = sw;
        clip_h  = sh;
        clip_dx = dx;
        clip_dy = dy;
        busy    = 1'b1;
      end else begin
        busy = 1'b0;
        p = '0;
        p.nothing_copied = 1'b1;
        expected_pairs.push_back(p);
      end
    end else if (busy) begin
      si = longint'(clip_sy + row) * src_w + clip_sx + col;
      di = longint'(clip_dy + row) * dst_w + clip_dx + col;
      p.src_index      = si[SRC_IDX_W-1:0];
      p.dst_index      = di[DST_IDX_W-1:0];
      p.last_pair      = (col + 1 >= clip_w) && (row + 1 >= clip_h);
      p.nothing_copied = 1'b0;
      expected_pairs.push_back(p);
      if (col + 1 < clip_w) begin
        col++;
      end else begin
        col = 0;
        row++;
      end
      if (p.last_pair) begin
        busy = 1'b0;
        col  = 0;
        row  = 0;
      end
    end
  endfunction

  always @(posedge clk) begin
    int v;
    pixel_pair_t want;
    if (!rst_n) begin
      src_w = int'(CFG_RESET_VAL);
      src_h = int'(CFG_RESET_VAL);
      dst_w = int'(CFG_RESET_VAL);
      dst_h = int'(CFG_RESET_VAL);
      clip_sx = 0;
      clip_sy = 0;
      clip_w  = 0;
      clip_h  = 0;
      clip_dx = 0;
      clip_dy = 0;
      col  = 0;
      row  = 0;
      busy = 1'b0;
      expected_pairs.delete();
      fail_count = 0;
    end else begin
      // results first: a transaction accepted at this edge cannot be answered at it
      if (out_tvalid && out_tready) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("result with nothing pending, src_index", out_tdata[25:0], 0);
        end else begin
          want = expected_pairs.pop_front();
          if (out_tdata[25:0] !== want.src_index)
            report_mismatch("src_index", out_tdata[25:0], want.src_index);
          if (out_tdata[49:26] !== want.dst_index)
            report_mismatch("dst_index", out_tdata[49:26], want.dst_index);
          if (out_tlast !== want.last_pair)
            report_mismatch("last_pair", out_tlast, want.last_pair);
          if (out_tuser !== want.nothing_copied)
            report_mismatch("nothing_copied", out_tuser, want.nothing_copied);
        end
      end
      if (cfg_valid && cfg_ready) begin
        v = int'(cfg_data);
        if (v > MAX_DIM) v = MAX_DIM;
        case (cfg_addr)
          CFG_SRC_W: src_w = v;
          CFG_SRC_H: src_h = v;
          CFG_DST_W: dst_w = v;
          CFG_DST_H: dst_h = v;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_pixel_pair(in_tuser, in_tdata);
    end
    pending = expected_pairs.size();
  end

endmodule

[tb/clipped_blit_address_generator_test.sv]
// clipped_blit_address_generator_test: drives blit starts, pixel steps and register writes
// with random idling on both sides and gives the verdict from the checker's count
// depends on cba_pkg, clipped_blit_address_generator and cba_blit_checker
`timescale 1ns / 1ps

module clipped_blit_address_generator_test;
  import cba_pkg::*;

  localparam int     MAX_DIM     = DEF_MAX_DIM;
  localparam int     LATENCY     = 3;
  localparam int     DRAIN_LIMIT = 20000;
  localparam longint TIMEOUT_NS  = 64'd5_000_000;
  // an index that no register decodes
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [DIM_W-1:0]      cfg_data;

  int failures;
  int pending_pairs;
  int items_sent;
  bit no_idle;
  bit out_no_stall;
  // effective dimensions, used only to shape the stimulus
  int eff_src_w, eff_src_h, eff_dst_w, eff_dst_h;

  clipped_blit_address_generator #(.MAX_DIM(MAX_DIM)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  cba_blit_checker #(.MAX_DIM(MAX_DIM)) pair_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .fail_count(failures), .pending(pending_pairs)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // result side: a fresh stall before every transaction, with stretches of none
  initial begin
    int stall;
    out_tready = 1'b0;
    out_no_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_no_stall = ~out_no_stall;
      stall = out_no_stall ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_item(input logic op, input int sx, sy, w, h, px, py);
    int gap;
    logic [IN_DATA_W-1:0] d;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    d = '0;
    d[11:0]  = 12'(sx);
    d[23:12] = 12'(sy);
    d[36:24] = 13'(w);
    d[49:37] = 13'(h);
    d[63:50] = 14'(px);
    d[77:64] = 14'(py);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // end any running blit with an empty start, then let the block drain
  task automatic settle();
    int waited;
    send_item(OP_START, 0, 0, 0, 0, 0, 0);
    @(negedge clk);
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_pairs != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (2 * LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= DIM_W'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int sw, sh, dw, dh);
    write_register(CFG_SRC_W, sw);
    write_register(CFG_SRC_H, sh);
    write_register(CFG_DST_W, dw);
    write_register(CFG_DST_H, dh);
    eff_src_w = (sw > MAX_DIM) ? MAX_DIM : sw;
    eff_src_h = (sh > MAX_DIM) ? MAX_DIM : sh;
    eff_dst_w = (dw > MAX_DIM) ? MAX_DIM : dw;
    eff_dst_h = (dh > MAX_DIM) ? MAX_DIM : dh;
  endtask

  // mostly small well-formed blits stepped to their end, the rest raw noise
  task automatic run_traffic(input int item_goal);
    int stop_at, w, h, sx, sy, px, py, steps, n;
    stop_at = items_sent + item_goal;
    while (items_sent < stop_at) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) != 0) begin
        w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 5);
        h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 4);
        sx = $urandom_range(0, (eff_src_w > 0) ? eff_src_w - 1 : 0);
        sy = $urandom_range(0, (eff_src_h > 0) ? eff_src_h - 1 : 0);
        px = int'($urandom_range(0, eff_dst_w + 4)) - 2;
        py = int'($urandom_range(0, eff_dst_h + 4)) - 2;
        if ($urandom_range(0, 4) == 0) px = -int'($urandom_range(1, w + 2));
        if ($urandom_range(0, 4) == 0) py = -int'($urandom_range(1, h + 2));
        send_item(OP_START, sx, sy, w, h, px, py);
        steps = w * h + $urandom_range(0, 2);
        // sometimes the next start cuts the blit short
        if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, w * h);
        if (steps > 80) steps = 80;
        repeat (steps) send_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom);
      end else begin
        send_item(OP_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        n = $urandom_range(0, 4);
        repeat (n) send_item(logic'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_START;
    cfg_valid  = 1'b0;
    cfg_addr   = CFG_SRC_W;
    cfg_data   = '0;
    items_sent = 0;
    no_idle    = 1'b0;
    eff_src_w  = int'(CFG_RESET_VAL);
    eff_src_h  = int'(CFG_RESET_VAL);
    eff_dst_w  = int'(CFG_RESET_VAL);
    eff_dst_h  = int'(CFG_RESET_VAL);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed cases on the reset dimensions of 256
    send_item(OP_START, 0, 0, 2, 2, -1, -1);          // both edges clipped to one pixel
    send_item(OP_STEP, 0, 0, 0, 0, 0, 0);
    send_item(OP_START, 250, 5, 4, 4, -10, 0);        // x shift passes source edge
    send_item(OP_START, 5, 250, 4, 4, 0, -10);        // y shift passes source edge
    send_item(OP_STEP, 0, 0, 0, 0, 0, 0);             // step while idle
    send_item(OP_START, 0, 0, 4, 4, 256, 0);          // starts right of destination
    send_item(OP_START, 0, 0, 4, 4, 0, 256);          // starts below destination
    send_item(OP_START, 0, 0, 0, 4, 0, 0);
    send_item(OP_START, 0, 0, 4, 0, 0, 0);
    send_item(OP_START, 100, 100, 8, 8, 254, 254);    // cut to 2x2 at the far corner
    repeat (4) send_item(OP_STEP, 0, 0, 0, 0, 0, 0);
    send_item(OP_START, 0, 0, 10, 10, 3, 3);
    repeat (2) send_item(OP_STEP, 0, 0, 0, 0, 0, 0);
    send_item(OP_START, 4095, 4095, 1, 1, 255, 255);  // replaces the running blit
    send_item(OP_STEP, 4095, 4095, 4096, 4096, -1, -1);
    send_item(OP_START, 4095, 4095, 4096, 4096, 8191, 8191);
    send_item(OP_START, 4095, 4095, 4096, 4096, -8192, -8192);
    send_item(OP_START, 0, 0, 4096, 4096, 0, 0);      // clipped to the whole destination
    repeat (2) send_item(OP_STEP, 0, 0, 0, 0, 0, 0);
    send_item(OP_START, 0, 0, 2, 3, -2, 0);           // shift leaves zero width
    settle();

    configure(4096, 4096, 4096, 4096);
    run_traffic(200);
    settle();
    configure(1, 1, 1, 1);
    run_traffic(150);
    settle();
    configure(8191, 5000, 17, 9);
    run_traffic(200);
    settle();
    configure($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
              $urandom_range(1, 64));
    run_traffic(200);
    settle();
    configure(0, 0, 12, 10);
    write_register(CFG_SPARE, 1);
    run_traffic(120);
    settle();
    configure(40, 30, 0, 0);
    run_traffic(60);
    settle();
    configure($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(1, 300),
              $urandom_range(1, 300));
    run_traffic(400);
    settle();

    if (failures == 0 && pending_pairs == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/cba_pkg.sv
src/cba_front.sv
src/cba_queue.sv
src/cba_back.sv
src/clipped_blit_address_generator.sv
tb/cba_blit_checker.sv
tb/clipped_blit_address_generator_test.sv
